@@ rtl/core/peak_hold_envelope_lookahead_assert.svh @@
// ----------------------------------------------------------------------------
// Peak-hold envelope: assertion macros
// Shared concurrent assertion forms for the envelope follower RTL.
// ----------------------------------------------------------------------------
`ifndef PEAK_HOLD_ENVELOPE_LOOKAHEAD_ASSERT_SVH
`define PEAK_HOLD_ENVELOPE_LOOKAHEAD_ASSERT_SVH

// same-cycle implication
`define PHEL_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define PHEL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/phel_pkg.sv @@
// ----------------------------------------------------------------------------
// phel_pkg
// Types and constants of the peak-hold envelope follower.
// ----------------------------------------------------------------------------
`default_nettype none

package phel_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int TAP_BITS      = 13;
    localparam int ADDR_W        = TAP_BITS;
    localparam int DELAY_DEPTH   = 2 ** ADDR_W;
    localparam int COEF_BITS     = 16;
    localparam int GAIN_FRAC     = 12;
    localparam int GAIN_PROD_W   = SAMPLE_BITS + COEF_BITS;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_INPUT_GAIN   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE_COEF = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_SAMPLES = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TOTAL_LAT    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOOKAHEAD    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DUCK_TAP     = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BAND_ACTIVE  = 3'd6;

    localparam logic [COEF_BITS-1:0] GAIN_UNITY = 16'd4096;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAIN,
        ST_DIFF,
        ST_UPD,
        ST_RD_TL,
        ST_RD_LA,
        ST_RD_DU,
        ST_DONE,
        ST_OUT
    } phel_state_t;

    typedef struct packed {
        logic                   wr_en;
        logic [SAMPLE_BITS-1:0] wr_data;
        logic                   rd_en;
        logic [TAP_BITS-1:0]    rd_tap;
        logic                   advance;
    } phel_dl_req_t;

endpackage

`default_nettype wire

@@ rtl/core/phel_delay_line.sv @@
// ----------------------------------------------------------------------------
// phel_delay_line
// Envelope delay memory with write pointer, tap addressing and fill tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module phel_delay_line (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire phel_pkg::phel_dl_req_t          req,
    output logic [phel_pkg::SAMPLE_BITS-1:0]     rd_data
);
    import phel_pkg::*;

    logic [SAMPLE_BITS-1:0] mem_ram [DELAY_DEPTH];
    logic [SAMPLE_BITS-1:0] rd_q_reg;
    logic [ADDR_W-1:0]      wr_idx_reg, wr_idx_next;
    logic                   wrapped_reg, wrapped_next;
    logic                   rd_ok_reg, rd_ok_next;
    logic [ADDR_W-1:0]      rd_addr;

    assign rd_addr = wr_idx_reg - req.rd_tap[ADDR_W-1:0];

    always_comb begin
        wr_idx_next  = wr_idx_reg;
        wrapped_next = wrapped_reg;
        rd_ok_next   = rd_ok_reg;
        if (req.rd_en) begin
            rd_ok_next = wrapped_reg || (rd_addr <= wr_idx_reg);
        end
        if (req.advance) begin
            wr_idx_next = wr_idx_reg + 1'b1;
            if (wr_idx_reg == '1) begin
                wrapped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_ram[wr_idx_reg] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_q_reg <= mem_ram[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg  <= '0;
            wrapped_reg <= 1'b0;
            rd_ok_reg   <= 1'b0;
        end else begin
            wr_idx_reg  <= wr_idx_next;
            wrapped_reg <= wrapped_next;
            rd_ok_reg   <= rd_ok_next;
        end
    end

    // never-written entries read as zero
    assign rd_data = rd_ok_reg ? rd_q_reg : '0;

endmodule

`default_nettype wire

@@ rtl/core/peak_hold_envelope_lookahead.sv @@
// Each input beat passes gain, difference and update steps; with the band active,
// three tap reads follow, and the three taps share the single read port of
// the delay memory. One beat is in flight at a time: the next input beat is
// accepted only once its result has moved into the output register, held while that is full.
// Reset: synchronous active-low aresetn clears peak, hold, pointer and fill state
// and loads the register defaults; the delay memory needs no clearing pass.
// ----------------------------------------------------------------------------
// peak_hold_envelope_lookahead
// Peak-hold envelope follower with release and delayed lookahead/duck taps.
// ----------------------------------------------------------------------------
`default_nettype none

module peak_hold_envelope_lookahead (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [phel_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire logic [phel_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [phel_pkg::SAMPLE_BITS-1:0] s_sample_in,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [phel_pkg::SAMPLE_BITS-1:0]           m_envelope_out
);
    import phel_pkg::*;

    phel_state_t state_reg, state_next;

    logic [COEF_BITS-1:0]   gain_reg, coef_reg, hold_samples_reg;
    logic [TAP_BITS-1:0]    tl_reg, la_reg, du_reg;
    logic                   active_reg;

    logic [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [SAMPLE_BITS-1:0] s_reg, s_next;
    logic [GAIN_PROD_W-1:0] prod_reg, prod_next;
    logic [SAMPLE_BITS-1:0] peak_reg, peak_next;
    logic [COEF_BITS-1:0]   hold_reg, hold_next;
    logic [SAMPLE_BITS-1:0] res_reg, res_next;
    logic [SAMPLE_BITS-1:0] out_reg, out_next;
    logic                   m_valid_reg, m_valid_next;

    logic [SAMPLE_BITS-1:0] mag;
    logic [GAIN_PROD_W-1:0] gain_prod;
    logic [GAIN_PROD_W-GAIN_FRAC-1:0] gain_shift;
    logic [SAMPLE_BITS-1:0] s_sat;
    logic [SAMPLE_BITS-1:0] diff;
    logic [SAMPLE_BITS-1:0] env;
    logic                   out_free;
    logic                   out_load;
    logic                   take_la, take_du;

    phel_dl_req_t           dl_req;
    logic [SAMPLE_BITS-1:0] dl_rd_data;

    phel_delay_line u_delay (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dl_req),
        .rd_data (dl_rd_data)
    );

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg         <= GAIN_UNITY;
            coef_reg         <= '0;
            hold_samples_reg <= '0;
            tl_reg           <= '0;
            la_reg           <= '0;
            du_reg           <= '0;
            active_reg       <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_INPUT_GAIN:   gain_reg         <= cfg_wdata;
                CFG_RELEASE_COEF: coef_reg         <= cfg_wdata;
                CFG_HOLD_SAMPLES: hold_samples_reg <= cfg_wdata;
                CFG_TOTAL_LAT:    tl_reg           <= cfg_wdata[TAP_BITS-1:0];
                CFG_LOOKAHEAD:    la_reg           <= cfg_wdata[TAP_BITS-1:0];
                CFG_DUCK_TAP:     du_reg           <= cfg_wdata[TAP_BITS-1:0];
                CFG_BAND_ACTIVE:  active_reg       <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign take_la  = la_reg < tl_reg;
    assign take_du  = du_reg > tl_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_GAIN;
            ST_GAIN:  state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_UPD;
            ST_UPD:   state_next = active_reg ? ST_RD_TL : ST_OUT;
            ST_RD_TL: state_next = ST_RD_LA;
            ST_RD_LA: state_next = ST_RD_DU;
            ST_RD_DU: state_next = ST_DONE;
            ST_DONE:  state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready        = 1'b0;
        out_load       = 1'b0;
        dl_req.wr_en   = 1'b0;
        dl_req.wr_data = env;
        dl_req.rd_en   = 1'b0;
        dl_req.rd_tap  = tl_reg;
        dl_req.advance = 1'b0;
        case (state_reg)
            ST_IDLE:  s_ready = 1'b1;
            ST_UPD: begin
                dl_req.wr_en   = 1'b1;
                dl_req.advance = !active_reg;
            end
            ST_RD_TL: dl_req.rd_en = 1'b1;
            ST_RD_LA: begin
                dl_req.rd_en  = 1'b1;
                dl_req.rd_tap = la_reg;
            end
            ST_RD_DU: begin
                dl_req.rd_en  = 1'b1;
                dl_req.rd_tap = du_reg;
            end
            ST_DONE:  dl_req.advance = 1'b1;
            ST_OUT:   out_load = out_free;
            default: ;
        endcase
    end

    // gain, rectify, saturate
    always_comb begin
        mag        = sample_reg[SAMPLE_BITS-1] ? (~sample_reg + 1'b1) : sample_reg;
        gain_prod  = GAIN_PROD_W'(mag) * GAIN_PROD_W'(gain_reg);
        gain_shift = gain_prod[GAIN_PROD_W-1:GAIN_FRAC];
        s_sat      = (|gain_shift[GAIN_PROD_W-GAIN_FRAC-1:SAMPLE_BITS]) ? '1
                                                         : gain_shift[SAMPLE_BITS-1:0];
        diff       = peak_reg - s_reg;
    end

    // peak, hold and release
    always_comb begin
        peak_next = peak_reg;
        hold_next = hold_reg;
        if (s_reg >= peak_reg) begin
            env       = s_reg;
            peak_next = s_reg;
            hold_next = hold_samples_reg;
        end else if (hold_reg != '0) begin
            env       = peak_reg;
            hold_next = hold_reg - 1'b1;
        end else begin
            env       = peak_reg - prod_reg[GAIN_PROD_W-1:COEF_BITS];
            peak_next = env;
        end
    end

    always_comb begin
        sample_next  = sample_reg;
        s_next       = s_reg;
        prod_next    = prod_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: sample_next = s_sample_in;
            ST_GAIN: s_next = s_sat;
            ST_DIFF: prod_next = GAIN_PROD_W'(diff) * GAIN_PROD_W'(coef_reg);
            ST_UPD:  res_next = env;
            ST_RD_LA: res_next = dl_rd_data;
            ST_RD_DU: if (take_la && dl_rd_data > res_reg) res_next = dl_rd_data;
            ST_DONE:  if (take_du && dl_rd_data > res_reg) res_next = dl_rd_data;
            default: ;
        endcase
        if (out_load) begin
            out_next     = res_reg;
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
        s_reg      <= s_next;
        prod_reg   <= prod_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            peak_reg    <= '0;
            hold_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == ST_UPD) begin
                peak_reg <= peak_next;
                hold_reg <= hold_next;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_envelope_out = out_reg;

`include "peak_hold_envelope_lookahead_assert.svh"

    `PHEL_ASSERT_NEXT(a_accept_starts, aclk, aresetn, s_valid && s_ready, state_reg == ST_GAIN)
    `PHEL_ASSERT_NOW(a_load_free, aclk, aresetn, out_load, !m_valid_reg || m_ready)
    `PHEL_ASSERT_NEXT(a_load_value, aclk, aresetn, out_load, m_valid && m_envelope_out == $past(res_reg))
    `PHEL_ASSERT_NEXT(a_peak_falls, aclk, aresetn, state_reg == ST_UPD && s_reg < peak_reg, peak_reg <= $past(peak_reg))

endmodule

`default_nettype wire

@@ sim/phel_env_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Envelope follower checker
// Watches the register port and both channels of the peak-hold envelope
// follower. Keeps its own gain, peak, hold and delay-line state, predicts the
// envelope for every accepted sample beat and compares result beats in order.
// ----------------------------------------------------------------------------
module phel_env_checker (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    cfg_wr_en,
    input  wire logic [phel_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  wire logic [phel_pkg::CFG_DATA_BITS-1:0]      cfg_wdata,
    input  wire logic                                    s_valid,
    input  wire logic                                    s_ready,
    input  wire logic signed [phel_pkg::SAMPLE_BITS-1:0] s_sample_in,
    input  wire logic                                    m_valid,
    input  wire logic                                    m_ready,
    input  wire logic [phel_pkg::SAMPLE_BITS-1:0]        m_envelope_out,
    output int                                           fail_count,
    output int                                           outstanding
);
    import phel_pkg::*;

    logic [COEF_BITS-1:0]   gain_reg;
    logic [COEF_BITS-1:0]   release_reg;
    logic [COEF_BITS-1:0]   hold_reg;
    logic [TAP_BITS-1:0]    latency_reg;
    logic [TAP_BITS-1:0]    lookahead_reg;
    logic [TAP_BITS-1:0]    duck_reg;
    logic                   active_reg;

    logic [SAMPLE_BITS-1:0] peak_hold;
    logic [COEF_BITS-1:0]   hold_count;
    logic [SAMPLE_BITS-1:0] env_history [DELAY_DEPTH];
    logic [TAP_BITS-1:0]    history_ptr;

    logic [SAMPLE_BITS-1:0] env_expected [$];
    logic [SAMPLE_BITS-1:0] env_next;
    logic [SAMPLE_BITS-1:0] env_want;

    function automatic logic [SAMPLE_BITS-1:0] history_tap(input logic [TAP_BITS-1:0] tap);
        logic [TAP_BITS-1:0] idx;
        idx = history_ptr - tap;
        return env_history[idx];
    endfunction

    task automatic apply_setting(input logic [CFG_IDX_BITS-1:0] idx,
                                 input logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            CFG_INPUT_GAIN:   gain_reg = data;
            CFG_RELEASE_COEF: release_reg = data;
            CFG_HOLD_SAMPLES: hold_reg = data;
            CFG_TOTAL_LAT:    latency_reg = data[TAP_BITS-1:0];
            CFG_LOOKAHEAD:    lookahead_reg = data[TAP_BITS-1:0];
            CFG_DUCK_TAP:     duck_reg = data[TAP_BITS-1:0];
            CFG_BAND_ACTIVE:  active_reg = data[0];
            default: ;
        endcase
    endtask

    task automatic follow_sample(input logic [SAMPLE_BITS-1:0] raw,
                                 output logic [SAMPLE_BITS-1:0] env_out);
        logic [SAMPLE_BITS-1:0] mag;
        logic [GAIN_PROD_W-1:0] scaled;
        logic [GAIN_PROD_W-1:0] drop;
        logic [SAMPLE_BITS-1:0] level;
        logic [SAMPLE_BITS-1:0] fall;
        logic [SAMPLE_BITS-1:0] tap_val;
        mag = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
        scaled = (GAIN_PROD_W'(mag) * GAIN_PROD_W'(gain_reg)) >> GAIN_FRAC;
        level = (scaled > {SAMPLE_BITS{1'b1}}) ? {SAMPLE_BITS{1'b1}} : scaled[SAMPLE_BITS-1:0];
        if (peak_hold > level) begin
            if (hold_count != '0) begin
                level = peak_hold;
                hold_count = hold_count - 1'b1;
            end else begin
                fall = peak_hold - level;
                drop = GAIN_PROD_W'(fall) * GAIN_PROD_W'(release_reg);
                level = peak_hold - drop[GAIN_PROD_W-1:COEF_BITS];
                peak_hold = level;
            end
        end else begin
            peak_hold = level;
            hold_count = hold_reg;
        end
        env_history[history_ptr] = level;
        if (active_reg) begin
            env_out = history_tap(latency_reg);
            if (lookahead_reg < latency_reg) begin
                tap_val = history_tap(lookahead_reg);
                if (tap_val > env_out) env_out = tap_val;
            end
            if (duck_reg > latency_reg) begin
                tap_val = history_tap(duck_reg);
                if (tap_val > env_out) env_out = tap_val;
            end
        end else begin
            env_out = level;
        end
        history_ptr = history_ptr + 1'b1;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg = GAIN_UNITY;
            release_reg = '0;
            hold_reg = '0;
            latency_reg = '0;
            lookahead_reg = '0;
            duck_reg = '0;
            active_reg = 1'b0;
            peak_hold = '0;
            hold_count = '0;
            history_ptr = '0;
            for (int i = 0; i < DELAY_DEPTH; i++) env_history[i] = '0;
            env_expected.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) apply_setting(cfg_index, cfg_wdata);
            if (s_valid && s_ready) begin
                follow_sample(s_sample_in, env_next);
                env_expected.push_back(env_next);
            end
            if (m_valid && m_ready) begin
                if (env_expected.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected envelope beat, expected none, actual %h",
                             $time, m_envelope_out);
                end else begin
                    env_want = env_expected.pop_front();
                    if (m_envelope_out !== env_want) begin
                        fail_count++;
                        $display("%0t: envelope mismatch, expected %h, actual %h",
                                 $time, env_want, m_envelope_out);
                    end
                end
            end
        end
        outstanding = env_expected.size();
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Peak-hold envelope follower testbench
// Drives directed edge cases and randomized sample streams through several
// register settings, with random gaps and back-pressure on both channels; the
// checker predicts each envelope beat and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import phel_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 10;
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_BEATS     = 190;
    localparam int CYCLE_LIMIT     = 400000;

    localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED = 3'd7;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic [CFG_IDX_BITS-1:0]       cfg_index;
    logic [CFG_DATA_BITS-1:0]      cfg_wdata;
    logic                          s_valid;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_sample_in;
    logic                          m_valid;
    logic                          m_ready;
    logic [SAMPLE_BITS-1:0]        m_envelope_out;

    int                            fail_count;
    int                            outstanding;
    logic                          tx_burst;
    logic                          rx_burst;
    logic [SAMPLE_BITS-1:0]        last_sample;

    peak_hold_envelope_lookahead u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_in    (s_sample_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_envelope_out (m_envelope_out)
    );

    phel_env_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_in    (s_sample_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_envelope_out (m_envelope_out),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_BITS-1:0] gain, coef, hold,
                                  input logic [CFG_DATA_BITS-1:0] lat, la, duck, act);
        wait_idle();
        write_reg(CFG_INPUT_GAIN, gain);
        write_reg(CFG_RELEASE_COEF, coef);
        write_reg(CFG_HOLD_SAMPLES, hold);
        write_reg(CFG_TOTAL_LAT, lat);
        write_reg(CFG_LOOKAHEAD, la);
        write_reg(CFG_DUCK_TAP, duck);
        write_reg(CFG_BAND_ACTIVE, act);
        cfg_wr_en = 1'b0;
    endtask

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_sample_in = value;
        do @(posedge aclk); while (!s_ready);
        last_sample = value;
        @(negedge aclk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] next_sample(input logic [SAMPLE_BITS-1:0] prev);
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5:       v = $urandom_range(0, 8191) - 4096;
            6:          v = int'(prev);
            7:          v = int'($signed(prev)) >>> $urandom_range(1, 4);
            8: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h007FFFFF;
                    1:       v = 32'h00800000;
                    2:       v = 0;
                    default: v = 32'h00FFFFFF;
                endcase
            end
            default:    v = int'(prev) - int'($urandom_range(0, 255));
        endcase
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_tap();
        logic [2:0] upper;
        upper = 3'($urandom);
        case ($urandom_range(0, 5))
            0:       return {upper, 13'd0};
            1:       return {upper, 13'h1FFF};
            2, 3:    return {upper, 13'($urandom_range(0, 32))};
            4:       return {upper, 13'($urandom_range(0, 300))};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_word();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int beats;
        int gap;
        m_ready = 1'b0;
        rx_burst = 1'b0;
        beats = 0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (beats % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
            if (beats == 300 || beats == 1100) begin
                m_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end
            gap = rx_burst ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            beats++;
            @(negedge aclk);
        end
    end

    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [CFG_DATA_BITS-1:0] gain;
        logic [CFG_DATA_BITS-1:0] coef;
        logic [CFG_DATA_BITS-1:0] hold;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_sample_in = '0;
        tx_burst = 1'b0;
        last_sample = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // register defaults: unity gain, raw envelope
        send_sample(24'h000000);
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);
        send_sample(24'hFFFFFF);
        send_sample(24'h000001);
        send_sample(24'h400000);

        // write to an unmapped index, then reuse defaults
        wait_idle();
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        cfg_wr_en = 1'b0;
        send_sample(24'h000010);

        // full gain saturation, hold, release, equal peak, active taps
        apply_settings(16'hFFFF, 16'hFFFF, 16'd2, 16'd3, 16'd1, 16'd5, 16'd1);
        send_sample(24'h800000);
        send_sample(24'h000100);
        send_sample(24'h000100);
        send_sample(24'h000100);
        send_sample(24'h000400);
        send_sample(24'hFFFC00);
        send_sample(24'h000000);
        send_sample(24'h000000);

        // zero gain, longest latency, taps not applied, longest hold
        apply_settings(16'h0000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h1FFF, 16'h0000, 16'hFFFF);
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);
        send_sample(24'h000000);

        // zero latency with the deepest duck tap
        apply_settings(GAIN_UNITY, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h1FFF, 16'h0001);
        send_sample(24'h7FFFFF);
        send_sample(24'h000000);
        send_sample(24'h000000);
        send_sample(24'h800000);
        send_sample(24'h000001);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 7))
                0:       gain = 16'h0000;
                1:       gain = 16'hFFFF;
                2, 3:    gain = GAIN_UNITY;
                default: gain = 16'($urandom);
            endcase
            coef = pick_word();
            case ($urandom_range(0, 7))
                0:       hold = 16'h0000;
                1:       hold = 16'hFFFF;
                2:       hold = 16'($urandom);
                default: hold = 16'($urandom_range(1, 16));
            endcase
            apply_settings(gain, coef, hold, pick_tap(), pick_tap(), pick_tap(),
                           (p % 4 == 3) ? 16'($urandom) & 16'hFFFE : 16'($urandom) | 16'h0001);
            for (int i = 0; i < PHASE_BEATS; i++) begin
                if (i % 48 == 0) tx_burst = ($urandom_range(0, 3) == 0);
                send_sample(next_sample(last_sample));
            end
            tx_burst = 1'b0;
        end

        wait_idle();
        if (fail_count == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
